// File: rtl/cpc_pkg.sv
package cpc_pkg;

	localparam int unsigned MaxVertices = 8;
	localparam int unsigned CoordW = 16;
	localparam int unsigned CountW = 4;
	localparam int unsigned TW = 17;
	localparam logic [TW-1:0] TOne = 17'h10000;

	// products of 17-bit differences, sums of two
	localparam int unsigned ProdW = 35;
	localparam int unsigned DotW = 36;
	localparam int unsigned DenW = 37;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_CLIP = 1'b1;

	typedef struct packed {
		logic                     command;
		logic [2:0]               vertex_index;
		logic signed [CoordW-1:0] vertex_x;
		logic signed [CoordW-1:0] vertex_y;
		logic signed [CoordW-1:0] start_x;
		logic signed [CoordW-1:0] start_y;
		logic signed [CoordW-1:0] end_x;
		logic signed [CoordW-1:0] end_y;
	} in_item_t;

	typedef struct packed {
		logic                     visible;
		logic signed [CoordW-1:0] clipped_start_x;
		logic signed [CoordW-1:0] clipped_start_y;
		logic signed [CoordW-1:0] clipped_end_x;
		logic signed [CoordW-1:0] clipped_end_y;
		logic [TW-1:0]            entry_param;
		logic [TW-1:0]            exit_param;
	} out_item_t;

	// divider control between sequencer and divider
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

// File: rtl/cpc_if.sv
interface cpc_in_if;
	logic                valid;
	logic                ready;
	cpc_pkg::in_item_t   data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cpc_out_if;
	logic                valid;
	logic                ready;
	cpc_pkg::out_item_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cpc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cpc_pkg::CountW-1:0]     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/cpc_div.sv
// Restoring divider: quo = floor(num * 2^16 / den), one quotient bit per cycle.
module cpc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [cpc_pkg::DotW-1:0]         num,
	input  logic [cpc_pkg::DenW-1:0]         den,
	output cpc_pkg::div_ctl_t                ctl,
	output logic [cpc_pkg::TW-1:0]           quo
);
	localparam int unsigned RemW = cpc_pkg::DenW + 1;
	localparam int unsigned NumW = cpc_pkg::DotW + 16;
	localparam int unsigned CntW = $clog2(NumW + 1);

	logic [NumW-1:0]            dvd_q;
	logic [RemW-1:0]            rem_q;
	logic [cpc_pkg::DenW-1:0]   den_q;
	logic [CntW-1:0]            cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [RemW-1:0]            shifted;
	logic [RemW-1:0]            diff;
	logic                       fits;
	// quotient bits beyond TW are provably zero since t <= 1
	logic [NumW-1:0]            quo_full_q;

	assign shifted = {rem_q[RemW-2:0], dvd_q[NumW-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = ~diff[RemW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q      <= {num, 16'h0};
			den_q      <= den;
			rem_q      <= '0;
			quo_full_q <= '0;
		end else if (busy_q) begin
			dvd_q      <= {dvd_q[NumW-2:0], 1'b0};
			rem_q      <= fits ? diff : shifted;
			quo_full_q <= {quo_full_q[NumW-2:0], fits};
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
	assign quo       = quo_full_q[cpc_pkg::TW-1:0];
endmodule

// File: rtl/cpc_seq.sv
// Sequencer: walks edges with one shared multiplier, one divider.
module cpc_seq #(
	parameter int unsigned MAX_VERTICES = cpc_pkg::MaxVertices
) (
	input  logic                      clk,
	input  logic                      arst_n,
	cpc_in_if.sink                    in_ch,
	cpc_out_if.source                 out_ch,
	input  logic [cpc_pkg::CountW-1:0] vertex_count,
	output logic                      idle
);
	localparam int unsigned IdxW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int unsigned CW   = cpc_pkg::CoordW;
	localparam int unsigned DW   = cpc_pkg::DotW;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RD    = 9'b000000010,
		S_M0    = 9'b000000100,
		S_M1    = 9'b000001000,
		S_M2    = 9'b000010000,
		S_M3    = 9'b000100000,
		S_TEST  = 9'b001000000,
		S_DIV   = 9'b010000000,
		S_LERP  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [31:0] store_q [MAX_VERTICES];
	logic [31:0] p_q, q_q;

	logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;
	logic [cpc_pkg::CountW-1:0] n_q;
	logic [IdxW:0]  i_q;
	logic [IdxW-1:0] i_idx, nxt_idx;
	logic [2:0]     step_q;
	logic signed [DW-1:0] c0_q, c1_q;
	logic signed [cpc_pkg::ProdW-1:0] prod_q;
	logic [cpc_pkg::TW-1:0] tin_q, tout_q;
	logic dropped_q;
	logic [2:0] lstep_q;

	// shared multiplier 18x18 signed
	logic signed [17:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [cpc_pkg::ProdW:0] mul_p;

	logic signed [17:0] px, py, qx, qy, nx, ny;
	logic signed [DW:0] den;
	logic [DW-1:0] num_mag;
	logic [cpc_pkg::DenW-1:0] den_mag;
	logic div_start;
	cpc_pkg::div_ctl_t div_ctl;
	logic [cpc_pkg::TW-1:0] quo;
	logic [cpc_pkg::TW-1:0] tin_n, tout_n;
	logic signed [17:0] vx, vy;
	logic signed [CW-1:0] lerp_r;
	logic [cpc_pkg::TW-1:0] t_sel;
	logic signed [17:0] base_sel, v_sel;
	logic signed [cpc_pkg::ProdW:0] lp;
	logic [cpc_pkg::ProdW:0] lp_neg;
	logic signed [17:0] lq;

	assign i_idx   = i_q[IdxW-1:0];
	assign nxt_idx = (32'(i_q) + 32'd1 >= 32'(n_q)) ? '0 : IdxW'(i_q + 1'b1);

	assign px = 18'(signed'(p_q[15:0]));
	assign py = 18'(signed'(p_q[31:16]));
	assign qx = 18'(signed'(q_q[15:0]));
	assign qy = 18'(signed'(q_q[31:16]));
	assign nx = qy - py;
	assign ny = px - qx;
	assign vx = 18'(bx_q) - 18'(ax_q);
	assign vy = 18'(by_q) - 18'(ay_q);

	always_comb begin
		case (step_q)
			3'd0:    begin mul_a = 18'(ax_q) - px; mul_b = nx; end
			3'd1:    begin mul_a = 18'(ay_q) - py; mul_b = ny; end
			3'd2:    begin mul_a = 18'(bx_q) - px; mul_b = nx; end
			3'd3:    begin mul_a = 18'(by_q) - py; mul_b = ny; end
			default: begin mul_a = v_sel; mul_b = 18'(signed'({1'b0, t_sel})); end
		endcase
	end
	assign mul_p = 36'(mul_a) * 36'(mul_b);

	assign den     = 37'(c1_q) - 37'(c0_q);
	assign num_mag = c0_q[DW-1] ? DW'(-c0_q) : DW'(c0_q);
	assign den_mag = den[DW] ? cpc_pkg::DenW'(-den) : cpc_pkg::DenW'(den);
	assign div_start = (state_q == S_TEST) && (c0_q > 0) != (c1_q > 0);

	cpc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_mag), .den(den_mag), .ctl(div_ctl), .quo(quo)
	);

	assign tout_n = (!den[DW] && quo < tout_q) ? quo : tout_q;
	assign tin_n  = (den[DW] && quo > tin_q) ? quo : tin_q;

	// lerp: endpoint = base + floor(t*v / 2^16)
	assign t_sel    = lstep_q[1] ? tout_q : tin_q;
	assign v_sel    = lstep_q[0] ? vy : vx;
	assign base_sel = lstep_q[0] ? 18'(ay_q) : 18'(ax_q);
	assign lp       = mul_p;
	assign lp_neg   = -lp;
	assign lq = lp[cpc_pkg::ProdW] ? 18'(-(signed'({1'b0, 18'((lp_neg + 36'hFFFF) >> 16)})))
		: 18'(lp >>> 16);
	assign lerp_r = CW'(base_sel + lq);

	assign in_ch.ready = (state_q == S_IDLE);
	assign idle = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready && in_ch.data.command == cpc_pkg::CMD_LOAD
			&& 32'(in_ch.data.vertex_index) < MAX_VERTICES)
			store_q[IdxW'(in_ch.data.vertex_index)] <= {in_ch.data.vertex_y, in_ch.data.vertex_x};
		if (state_q == S_RD) begin
			p_q <= store_q[i_idx];
			q_q <= store_q[nxt_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_ch.valid <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready && in_ch.data.command == cpc_pkg::CMD_CLIP) begin
						ax_q <= in_ch.data.start_x; ay_q <= in_ch.data.start_y;
						bx_q <= in_ch.data.end_x;   by_q <= in_ch.data.end_y;
						n_q  <= (32'(vertex_count) > MAX_VERTICES) ?
							cpc_pkg::CountW'(MAX_VERTICES) : vertex_count;
						i_q <= '0; tin_q <= '0; tout_q <= cpc_pkg::TOne; dropped_q <= 1'b0;
						lstep_q <= '0; step_q <= 3'd4;
						state_q <= (vertex_count >= 4'd3) ? S_RD : S_LERP;
					end
				end
				S_RD: begin step_q <= 3'd0; state_q <= S_M0; end
				S_M0: begin prod_q <= cpc_pkg::ProdW'(mul_p); step_q <= 3'd1; state_q <= S_M1; end
				S_M1: begin
					c0_q <= DW'(prod_q) + DW'(mul_p); step_q <= 3'd2; state_q <= S_M2;
				end
				S_M2: begin prod_q <= cpc_pkg::ProdW'(mul_p); step_q <= 3'd3; state_q <= S_M3; end
				S_M3: begin
					c1_q <= DW'(prod_q) + DW'(mul_p); step_q <= 3'd4; state_q <= S_TEST;
				end
				S_TEST: begin
					if (c0_q > 0 && c1_q > 0) begin
						dropped_q <= 1'b1; state_q <= S_LERP;
					end else if (div_start) begin
						state_q <= S_DIV;
					end else if (i_q + 1'b1 >= (IdxW+1)'(n_q)) begin
						state_q <= S_LERP;
					end else begin
						i_q <= i_q + 1'b1; state_q <= S_RD;
					end
				end
				S_DIV: begin
					if (div_ctl.done) begin
						tin_q <= tin_n; tout_q <= tout_n;
						if (tin_n > tout_n) begin
							dropped_q <= 1'b1; state_q <= S_LERP;
						end else if (i_q + 1'b1 >= (IdxW+1)'(n_q)) begin
							state_q <= S_LERP;
						end else begin
							i_q <= i_q + 1'b1; state_q <= S_RD;
						end
					end
				end
				S_LERP: begin
					// hold while the previous result still waits
					if (!out_ch.valid || out_ch.ready) begin
						case (lstep_q[1:0])
							2'd0: out_ch.data.clipped_start_x <= lerp_r;
							2'd1: out_ch.data.clipped_start_y <= lerp_r;
							2'd2: out_ch.data.clipped_end_x   <= lerp_r;
							default: out_ch.data.clipped_end_y <= lerp_r;
						endcase
						lstep_q <= lstep_q + 1'b1;
						if (lstep_q[1:0] == 2'd3) begin
							out_ch.data.visible     <= !dropped_q;
							out_ch.data.entry_param <= dropped_q ? '0 : tin_q;
							out_ch.data.exit_param  <= dropped_q ? '0 : tout_q;
							if (dropped_q) begin
								out_ch.data.clipped_start_x <= '0;
								out_ch.data.clipped_start_y <= '0;
								out_ch.data.clipped_end_x   <= '0;
								out_ch.data.clipped_end_y   <= '0;
							end
							out_ch.valid <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/convex_polygon_line_clipper.sv
// Cyrus-Beck line clipper against a convex polygon of up to MAX_VERTICES
// vertices. Load items (command 0) write one vertex. A clip item walks each
// edge, up to the vertex count capped at MAX_VERTICES, through a read, four
// multiply steps and a test, runs the bit-serial restoring divider for each
// edge the line crosses, and then forms the endpoints. The input is not
// ready while a clip runs; a clip whose predecessor's result still waits to be
// taken holds before forming its endpoints.
module convex_polygon_line_clipper #(
	parameter int unsigned MAX_VERTICES = cpc_pkg::MaxVertices
) (
	input  logic         clk,
	input  logic         arst_n,
	cpc_in_if.sink       in_ch,
	cpc_out_if.source    out_ch,
	cpc_cfg_if.sink      cfg
);
	logic [cpc_pkg::CountW-1:0] vertex_count_q;
	logic idle;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vertex_count_q <= '0;
		else if (cfg.valid) vertex_count_q <= cfg.data;
	end

	cpc_seq #(.MAX_VERTICES(MAX_VERTICES)) u_seq (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.vertex_count(vertex_count_q), .idle(idle)
	);

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> idle) else $error("ready while busy");
	a_visible_params: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.visible |->
		out_ch.data.entry_param <= out_ch.data.exit_param) else $error("entry past exit");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed while stalled");
endmodule

// File: tb/sv/convex_polygon_line_clipper_tb.sv
module convex_polygon_line_clipper_tb;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [3:0]           count;
		cpc_pkg::in_item_t    item;
		bit                   typed;
		cpc_pkg::out_item_t   want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	cpc_in_if  in_ch();
	cpc_out_if out_ch();
	cpc_cfg_if cfg();

	convex_polygon_line_clipper dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	// polygon mirror of the block
	logic signed [cpc_pkg::CoordW-1:0] corner_x [cpc_pkg::MaxVertices];
	logic signed [cpc_pkg::CoordW-1:0] corner_y [cpc_pkg::MaxVertices];
	logic [cpc_pkg::CountW-1:0]        corner_count;

	cpc_pkg::out_item_t   pending_clips[$];
	stim_row_t            directed[$];
	int          mismatches;
	int          tx_idle;
	int          rx_idle;
	int          sent;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("** convex_polygon_line_clipper: FAILED **");
		$finish;
	end

	function automatic cpc_pkg::out_item_t clip_segment(cpc_pkg::in_item_t it);
		cpc_pkg::out_item_t r;
		longint ax, ay, vx, vy, px, py, nx, ny, c0, c1, den, num, dmag, t;
		longint t_in, t_out;
		int n, j;
		ax = it.start_x;
		ay = it.start_y;
		vx = longint'(it.end_x) - ax;
		vy = longint'(it.end_y) - ay;
		t_in = 0;
		t_out = 65536;
		r = '0;
		n = (corner_count > cpc_pkg::MaxVertices) ? cpc_pkg::MaxVertices : corner_count;
		if (n >= 3) begin
			for (int i = 0; i < n; i++) begin
				j = (i + 1) % n;
				px = corner_x[i];
				py = corner_y[i];
				nx = longint'(corner_y[j]) - py;
				ny = px - longint'(corner_x[j]);
				c0 = (ax - px) * nx + (ay - py) * ny;
				c1 = (ax + vx - px) * nx + (ay + vy - py) * ny;
				if (c0 <= 0 && c1 <= 0)
					continue;
				if (c0 > 0 && c1 > 0)
					return r;
				den = c1 - c0;
				num = (c0 < 0) ? -c0 : c0;
				dmag = (den < 0) ? -den : den;
				t = (num << 16) / dmag;
				if (den > 0 && t < t_out)
					t_out = t;
				else if (den < 0 && t > t_in)
					t_in = t;
				if (t_in > t_out)
					return r;
			end
		end
		// floor of the product, as arithmetic shift
		r.visible = 1'b1;
		r.clipped_start_x = 16'(ax + ((vx * t_in) >>> 16));
		r.clipped_start_y = 16'(ay + ((vy * t_in) >>> 16));
		r.clipped_end_x = 16'(ax + ((vx * t_out) >>> 16));
		r.clipped_end_y = 16'(ay + ((vy * t_out) >>> 16));
		r.entry_param = 17'(t_in);
		r.exit_param = 17'(t_out);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin
		cpc_pkg::out_item_t g, w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			g = out_ch.data;
			if (pending_clips.size() == 0) begin
				report_mismatch("unexpected clip transaction", g.visible, -1);
			end else begin
				w = pending_clips.pop_front();
				if (g.visible !== w.visible)
					report_mismatch("visible", g.visible, w.visible);
				if (g.clipped_start_x !== w.clipped_start_x)
					report_mismatch("clipped_start_x", g.clipped_start_x, w.clipped_start_x);
				if (g.clipped_start_y !== w.clipped_start_y)
					report_mismatch("clipped_start_y", g.clipped_start_y, w.clipped_start_y);
				if (g.clipped_end_x !== w.clipped_end_x)
					report_mismatch("clipped_end_x", g.clipped_end_x, w.clipped_end_x);
				if (g.clipped_end_y !== w.clipped_end_y)
					report_mismatch("clipped_end_y", g.clipped_end_y, w.clipped_end_y);
				if (g.entry_param !== w.entry_param)
					report_mismatch("entry_param", g.entry_param, w.entry_param);
				if (g.exit_param !== w.exit_param)
					report_mismatch("exit_param", g.exit_param, w.exit_param);
			end
		end
		out_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
	end

	task automatic send_item(cpc_pkg::in_item_t it, bit typed, cpc_pkg::out_item_t want);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
		if (it.command == cpc_pkg::CMD_LOAD) begin
			corner_x[it.vertex_index] = it.vertex_x;
			corner_y[it.vertex_index] = it.vertex_y;
		end else begin
			pending_clips.insert(pending_clips.size(), typed ? want : clip_segment(it));
		end
	endtask

	// hold input off until every clip has returned, then let a load settle
	task automatic drain;
		in_ch.valid <= 1'b0;
		while (pending_clips.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_count(logic [3:0] n);
		drain();
		cfg.valid <= 1'b1;
		cfg.data <= n;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		corner_count = n;
	endtask

	function automatic cpc_pkg::in_item_t load_item(int idx, int x, int y);
		cpc_pkg::in_item_t it;
		it = '0;
		it.command = cpc_pkg::CMD_LOAD;
		it.vertex_index = 3'(idx);
		it.vertex_x = 16'(x);
		it.vertex_y = 16'(y);
		it.start_x = 16'($urandom);
		it.end_y = 16'($urandom);
		return it;
	endfunction

	function automatic cpc_pkg::in_item_t clip_item(int sx, int sy, int ex, int ey);
		cpc_pkg::in_item_t it;
		it = '0;
		it.command = cpc_pkg::CMD_CLIP;
		it.vertex_index = 3'($urandom);
		it.vertex_x = 16'($urandom);
		it.vertex_y = 16'($urandom);
		it.start_x = 16'(sx);
		it.start_y = 16'(sy);
		it.end_x = 16'(ex);
		it.end_y = 16'(ey);
		return it;
	endfunction

	function automatic int rand_coord(int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	task automatic add_row(row_kind_t k, logic [3:0] n, cpc_pkg::in_item_t it, bit typed,
		cpc_pkg::out_item_t want);
		stim_row_t r;
		r.kind = k;
		r.count = n;
		r.item = it;
		r.typed = typed;
		r.want = want;
		directed.insert(directed.size(), r);
	endtask

	// CCW polygon on a jittered circle, sometimes plain noise
	task automatic load_polygon;
		real cx, cy, rad, ang;
		bit noise;
		cx = rand_coord(6000);
		cy = rand_coord(6000);
		rad = $urandom_range(1500, 15000);
		noise = ($urandom_range(0, 9) == 0);
		for (int i = 0; i < cpc_pkg::MaxVertices; i++) begin
			ang = 6.283185307 * (i + 0.8 * ($urandom_range(0, 1000) / 1000.0)) / 8.0;
			if (noise)
				send_item(load_item(i, rand_coord(32768), rand_coord(32768)), 0, '0);
			else
				send_item(load_item(i, $rtoi(cx + rad * $cos(ang)),
					$rtoi(cy + rad * $sin(ang))), 0, '0);
		end
	endtask

	task automatic random_phase(int quota);
		int stop;
		int sx, sy, ex, ey;
		logic [3:0] n;
		stop = sent + quota;
		while (sent < stop) begin
			case ($urandom_range(0, 9))
				0: n = 4'($urandom_range(0, 2));
				1: n = 4'($urandom_range(9, 15));
				2: n = 4'd8;
				default: n = 4'($urandom_range(3, 8));
			endcase
			write_count(n);
			load_polygon();
			repeat ($urandom_range(20, 40)) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						sx = rand_coord(32768);
						sy = rand_coord(32768);
						ex = rand_coord(32768);
						ey = rand_coord(32768);
					end
					2: begin
						sx = rand_coord(4000);
						sy = rand_coord(4000);
						ex = sx;
						ey = sy;
					end
					3: begin
						sx = rand_coord(3000);
						sy = rand_coord(3000);
						ex = rand_coord(32768);
						ey = rand_coord(32768);
					end
					default: begin
						sx = rand_coord(20000);
						sy = rand_coord(20000);
						ex = rand_coord(20000);
						ey = rand_coord(20000);
					end
				endcase
				if (sx > 32767) sx = 32767;
				if (ex > 32767) ex = 32767;
				if (sy > 32767) sy = 32767;
				if (ey > 32767) ey = 32767;
				if ($urandom_range(0, 19) == 0)
					send_item(load_item($urandom_range(0, 7), rand_coord(12000),
						rand_coord(12000)), 0, '0);
				send_item(clip_item(sx, sy, ex, ey), 0, '0);
			end
		end
	endtask

	initial begin
		cpc_pkg::out_item_t pass_0, dropped;
		mismatches = 0;
		sent = 0;
		corner_count = '0;
		tx_idle = 27;
		rx_idle = 47;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		cfg.valid <= 1'b0;
		cfg.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dropped = '0;
		pass_0 = '{1'b1, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 17'd0,
			cpc_pkg::TOne};
		// too few vertices: lines pass unclipped
		add_row(ROW_ITEM, 0, clip_item(-32768, -32768, 32767, 32767), 1, pass_0);
		add_row(ROW_ITEM, 0, clip_item(0, 0, 0, 0), 1,
			'{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'd0, cpc_pkg::TOne});
		add_row(ROW_ITEM, 0, load_item(0, -8192, -8192), 0, '0);
		add_row(ROW_ITEM, 0, load_item(1, 8192, -8192), 0, '0);
		add_row(ROW_ITEM, 0, load_item(2, 8192, 8192), 0, '0);
		add_row(ROW_ITEM, 0, load_item(3, -8192, 8192), 0, '0);
		add_row(ROW_ITEM, 0, load_item(4, 0, 32767), 0, '0);
		add_row(ROW_ITEM, 0, load_item(5, -32768, 0), 0, '0);
		add_row(ROW_ITEM, 0, load_item(6, -32768, 32767), 0, '0);
		add_row(ROW_ITEM, 0, load_item(7, 32767, -32768), 0, '0);
		add_row(ROW_CFG, 2, '0, 0, '0);
		add_row(ROW_ITEM, 0, clip_item(-32768, -32768, 32767, 32767), 1, pass_0);
		add_row(ROW_CFG, 4, '0, 0, '0);
		// both ends beyond the right edge: dropped
		add_row(ROW_ITEM, 0, clip_item(16384, 0, 20000, 0), 1, dropped);
		add_row(ROW_ITEM, 0, clip_item(-32768, 0, 32767, 0), 0, '0);
		add_row(ROW_ITEM, 0, clip_item(-4000, 1000, 3000, -2000), 0, '0);
		add_row(ROW_ITEM, 0, clip_item(32767, 32767, -32768, -32768), 0, '0);
		// misses a corner: both ends beyond the top edge, dropped
		add_row(ROW_ITEM, 0, clip_item(-16384, 12288, 0, 32767), 0, '0);
		add_row(ROW_ITEM, 0, clip_item(8192, -8192, 8192, 8192), 0, '0);
		add_row(ROW_CFG, 15, '0, 0, '0);
		add_row(ROW_ITEM, 0, clip_item(-32768, 32767, 32767, -32768), 0, '0);
		add_row(ROW_CFG, 3, '0, 0, '0);
		add_row(ROW_ITEM, 0, clip_item(-32768, -4000, 32767, 4000), 0, '0);
		add_row(ROW_CFG, 8, '0, 0, '0);
		add_row(ROW_ITEM, 0, clip_item(0, 0, 100, 100), 0, '0);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG)
				write_count(directed[i].count);
			else
				send_item(directed[i].item, directed[i].typed, directed[i].want);
		end

		random_phase(410);
		drain();
		tx_idle = 47;
		rx_idle = 27;
		random_phase(410);
		drain();
		tx_idle = 0;
		rx_idle = 0;
		random_phase(410);

		in_ch.valid <= 1'b0;
		while (pending_clips.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("** convex_polygon_line_clipper: PASSED **");
		else
			$display("** convex_polygon_line_clipper: FAILED **");
		$finish;
	end

endmodule
